// ===== design/pave_pkg.sv =====
// package for the polar angle vector encoder
// holds sizes, cordic constants, controller command and status types
package pave_pkg;

  localparam int unsigned MaxDim      = 64;
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned ElemW       = 24;
  localparam int unsigned LenW        = 7;
  localparam int unsigned BitsW       = 4;
  localparam int unsigned RadW        = 32;
  localparam int unsigned IdxW        = 6;
  localparam int unsigned CalcW       = 64;
  localparam int unsigned AngW        = 34;

  localparam logic [0:0] CfgLen  = 1'b0;
  localparam logic [0:0] CfgBits = 1'b1;

  localparam logic [AngW-1:0] HalfPi = AngW'(64'sd1073741824);
  localparam logic [AngW-1:0] Pi     = AngW'(64'sd2147483648);
  localparam logic [31:0]     InvGain = 32'd652032874;

  function automatic logic [AngW-1:0] atan_lut(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0: v = 32'd536870912;  5'd1: v = 32'd316933406;
      5'd2: v = 32'd167458907;  5'd3: v = 32'd85004756;
      5'd4: v = 32'd42667331;   5'd5: v = 32'd21354465;
      5'd6: v = 32'd10679838;   5'd7: v = 32'd5340245;
      5'd8: v = 32'd2670163;    5'd9: v = 32'd1335087;
      5'd10: v = 32'd667544;    5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;    5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;     5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;     5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;       5'd21: v = 32'd326;
      5'd22: v = 32'd163;       5'd23: v = 32'd81;
      5'd24: v = 32'd41;        5'd25: v = 32'd20;
      5'd26: v = 32'd10;        5'd27: v = 32'd5;
      5'd28: v = 32'd3;         5'd29: v = 32'd1;
      5'd30: v = 32'd1;         default: v = 32'd0;
    endcase
    return {{(AngW-32){1'b0}}, v};
  endfunction

  // controller commands to the datapath
  typedef struct packed {
    logic load;       // store input element
    logic rd_pair;    // read pair at rd index
    logic cordic_go;  // start a pair
    logic wr_level;   // write level result
    logic copy_odd;   // move odd leftover
    logic rd_root;    // read root into radius
    logic clr_pack;   // clear byte packer
    logic pack;       // add one bucket to packer
    logic emit;       // push a byte into the output register
    logic emit_last;
  } cmd_t;

  typedef struct packed {
    logic cordic_done;
    logic out_full;
  } sts_t;

endpackage

// ===== design/pave_dp.sv =====
// datapath: level store, bucket store, shared cordic unit, byte packer, output register
// depends on pave_pkg
module pave_dp #(
  parameter int unsigned MAX_DIM      = pave_pkg::MaxDim,
  parameter int unsigned CORDIC_STEPS = pave_pkg::CordicSteps,
  localparam int unsigned AW = $clog2(MAX_DIM)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pave_pkg::cmd_t                cmd_i,
  output pave_pkg::sts_t                sts_o,
  input  logic [AW-1:0]                 wr_idx_i,
  input  logic [AW-1:0]                 rd_idx_i,
  input  logic [AW-1:0]                 bk_idx_i,
  input  logic                          bk_full_i,
  input  logic [3:0]                    bits_i,
  input  logic [pave_pkg::ElemW-1:0]    element_i,
  input  logic [5:0]                    byte_idx_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [7:0]                    code_byte_o,
  output logic [5:0]                    byte_index_o,
  output logic [pave_pkg::RadW-1:0]     radius_o,
  output logic                          last_o
);
  import pave_pkg::*;

  localparam int unsigned SW = $clog2(CORDIC_STEPS + 1);

  logic signed [31:0] lvl_mem [MAX_DIM];
  logic [7:0]         bk_mem  [MAX_DIM];
  logic signed [31:0] rx_q, ry_q;
  logic [7:0]         bk_rd_q;

  logic signed [CalcW-1:0] x_q, y_q, x_d, y_d;
  logic signed [AngW-1:0]  z_q, z_d;
  logic [SW-1:0]           it_q;
  logic [1:0]              ph_q;   // 0 idle,1 prep,2 iterate,3 scale
  logic                    done_q;
  logic [31:0]             mag_q;
  logic [63:0]             prod_q;
  logic [1:0]              scl_q;

  logic [15:0] acc_q;
  logic [4:0]  cnt_q;
  logic [31:0] rad_q;

  logic       ov_q;
  logic [7:0] ob_q;
  logic [5:0] oi_q;
  logic       ol_q;
  logic [31:0] or_q;

  // level store, one write port and two read ports that fetch a pair; odd and root use the same pair read
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) lvl_mem[wr_idx_i] <= 32'(signed'(element_i));
    else if (cmd_i.wr_level) lvl_mem[wr_idx_i] <= signed'(mag_q);
    else if (cmd_i.copy_odd) lvl_mem[wr_idx_i] <= rx_q;
    if (cmd_i.rd_pair) begin
      rx_q <= lvl_mem[rd_idx_i];
      ry_q <= lvl_mem[rd_idx_i | AW'(1)];
    end
  end

  // bucket store
  logic signed [AngW-1:0] qn;
  logic [7:0]             bucket;
  always_comb begin
    qn = z_q + signed'(HalfPi);
    if (qn < 0) qn = '0;
    if (qn > signed'(Pi - AngW'(1))) qn = signed'(Pi - AngW'(1));
    if (bk_full_i) bucket = 8'(z_q[31:0] >> (6'd32 - 6'(bits_i)));
    else           bucket = 8'(qn[30:0] >> (5'd31 - 5'(bits_i)));
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_level) bk_mem[bk_idx_i] <= bucket;
    bk_rd_q <= bk_mem[bk_idx_i];
  end

  // cordic unit, one micro rotation per cycle
  logic signed [CalcW-1:0] ex, ey, dx, dy;
  logic [4:0]              il;
  logic [63:0]             xp;
  logic [31:0]             hi_p;
  assign ex = CalcW'(rx_q);
  assign ey = CalcW'(ry_q);
  assign il = 5'(it_q);
  assign dx = y_q >>> il;
  assign dy = x_q >>> il;
  // gain product split in two 32 by 32 halves, wraps at 64 bits
  assign xp   = x_q < 0 ? 64'd0 : 64'(x_q);
  assign hi_p = xp[63:32] * InvGain;
  always_comb begin
    x_d = x_q; y_d = y_q; z_d = z_q;
    if (y_q >= 0) begin
      x_d = x_q + dx; y_d = y_q - dy; z_d = z_q + signed'(atan_lut(il));
    end else begin
      x_d = x_q - dx; y_d = y_q + dy; z_d = z_q - signed'(atan_lut(il));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= 2'd0;
      done_q <= 1'b0;
      it_q   <= '0;
      scl_q  <= 2'd0;
    end else begin
      done_q <= 1'b0;
      case (ph_q)
        2'd0: begin
          if (cmd_i.cordic_go) ph_q <= 2'd1;
        end
        2'd1: begin
          it_q <= '0;
          if (ry_q == 0) begin
            mag_q  <= ex < 0 ? 32'(-ex) : 32'(ex);
            z_q    <= ex < 0 ? signed'(Pi) : '0;
            done_q <= 1'b1; ph_q <= 2'd0;
          end else if (rx_q == 0) begin
            mag_q  <= ey < 0 ? 32'(-ey) : 32'(ey);
            z_q    <= ey > 0 ? signed'(HalfPi) : -signed'(HalfPi);
            done_q <= 1'b1; ph_q <= 2'd0;
          end else begin
            if (rx_q < 0 && ry_q > 0) begin
              x_q <= ey <<< 4; y_q <= (-ex) <<< 4; z_q <= signed'(HalfPi);
            end else if (rx_q < 0) begin
              x_q <= (-ey) <<< 4; y_q <= ex <<< 4; z_q <= -signed'(HalfPi);
            end else begin
              x_q <= ex <<< 4; y_q <= ey <<< 4; z_q <= '0;
            end
            ph_q <= 2'd2;
          end
        end
        2'd2: begin
          if (it_q == SW'(CORDIC_STEPS)) begin
            ph_q <= 2'd3; scl_q <= 2'd0;
          end else begin
            x_q <= x_d; y_q <= y_d; z_q <= z_d;
            it_q <= it_q + SW'(1);
          end
        end
        default: begin
          case (scl_q)
            2'd0: begin
              prod_q <= 64'(xp[31:0]) * 64'(InvGain);
              scl_q  <= 2'd1;
            end
            2'd1: begin
              prod_q <= prod_q + {hi_p, 32'd0};
              scl_q  <= 2'd2;
            end
            default: begin
              logic [63:0] r;
              r = (prod_q + (64'd1 << 33)) >> 34;
              mag_q  <= r > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : r[31:0];
              done_q <= 1'b1; ph_q <= 2'd0;
            end
          endcase
        end
      endcase
    end
  end
  assign sts_o.cordic_done = done_q;

  // byte packer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0; cnt_q <= '0; ov_q <= 1'b0;
    end else begin
      if (cmd_i.clr_pack) begin
        acc_q <= '0; cnt_q <= '0;
      end else if (cmd_i.pack) begin
        acc_q <= acc_q | (16'((bk_rd_q & 8'((9'd1 << bits_i) - 9'd1))) << cnt_q);
        cnt_q <= cnt_q + 5'(bits_i);
      end else if (cmd_i.emit) begin
        acc_q <= acc_q >> 8;
        cnt_q <= cnt_q > 5'd8 ? cnt_q - 5'd8 : 5'd0;
      end
      if (cmd_i.emit) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
    end
  end
  // radius travels with each beat, the next vector may overwrite rad_q
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_root) rad_q <= rx_q < 0 ? 32'(-rx_q) : 32'(rx_q);
    if (cmd_i.emit) begin
      ob_q <= acc_q[7:0]; oi_q <= byte_idx_i; ol_q <= cmd_i.emit_last;
      or_q <= rad_q;
    end
  end

  assign sts_o.out_full = ov_q && out_stall_i;
  assign out_valid_o  = ov_q;
  assign code_byte_o  = ob_q;
  assign byte_index_o = oi_q;
  assign radius_o     = or_q;
  assign last_o       = ol_q;
endmodule

// ===== design/pave_ctrl.sv =====
// controller: load counting, tree sequencing, packing and byte emission
// depends on pave_pkg
module pave_ctrl #(
  parameter int unsigned MAX_DIM = pave_pkg::MaxDim,
  localparam int unsigned AW = $clog2(MAX_DIM)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [0:0]                 cfg_index_i,
  input  logic [pave_pkg::LenW-1:0]  cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  pave_pkg::sts_t             sts_i,
  output pave_pkg::cmd_t             cmd_o,
  output logic [AW-1:0]              wr_idx_o,
  output logic [AW-1:0]              rd_idx_o,
  output logic [AW-1:0]              bk_idx_o,
  output logic                       bk_full_o,
  output logic [3:0]                 bits_o,
  output logic [5:0]                 byte_idx_o
);
  import pave_pkg::*;

  localparam logic [3:0] S_LOAD = 4'd0, S_RD = 4'd1, S_GO = 4'd2, S_WAIT = 4'd3,
                         S_ODD = 4'd4, S_ODDW = 4'd5, S_ROOT = 4'd6,
                         S_ROOTW = 4'd7, S_BKRD = 4'd8, S_PACK = 4'd9,
                         S_EMIT = 4'd10;

  logic [3:0]      st_q;
  logic [LenW-1:0] len_q, cnt_q, n_q, len_c;
  logic [3:0]      bits_q, bits_c;
  logic [LenW-1:0] pair_q, k_q, bkp_q;
  logic [5:0]      byte_q;
  logic [9:0]      tot_q, done_q;   // total code bits, bits packed
  logic [4:0]      fill_q;

  always_comb begin
    len_c  = len_q < LenW'(2) ? LenW'(2) : (len_q > LenW'(MAX_DIM) ? LenW'(MAX_DIM) : len_q);
    bits_c = bits_q == 4'd0 ? 4'd1 : (bits_q > 4'd8 ? 4'd8 : bits_q);
  end

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = st_q != S_LOAD;
  assign bits_o      = bits_c;
  assign byte_idx_o  = byte_q;
  assign bk_full_o   = k_q + LenW'(2) == len_c;

  always_comb begin
    cmd_o    = '0;
    wr_idx_o = AW'(pair_q);
    rd_idx_o = AW'({pair_q, 1'b0});
    bk_idx_o = AW'(k_q);
    case (st_q)
      S_LOAD: begin
        cmd_o.load = in_valid_i && cnt_q < LenW'(MAX_DIM);
        wr_idx_o   = AW'(cnt_q);
      end
      S_RD:   cmd_o.rd_pair = 1'b1;
      S_GO:   cmd_o.cordic_go = 1'b1;
      S_WAIT: cmd_o.wr_level = sts_i.cordic_done;
      S_ODD: begin
        cmd_o.rd_pair = 1'b1;
        rd_idx_o = AW'(n_q - LenW'(1));
      end
      S_ODDW: cmd_o.copy_odd = 1'b1;
      S_ROOT: begin
        cmd_o.rd_pair = 1'b1; rd_idx_o = '0;
      end
      S_ROOTW: begin
        cmd_o.rd_root = 1'b1; cmd_o.clr_pack = 1'b1;
      end
      S_BKRD: bk_idx_o = AW'(bkp_q);
      S_PACK: begin
        bk_idx_o = AW'(bkp_q);
        if (fill_q >= 5'd8 || (done_q >= tot_q && fill_q != 5'd0)) begin
          if (!sts_i.out_full) begin
            cmd_o.emit = 1'b1;
            cmd_o.emit_last = done_q >= tot_q && fill_q <= 5'd8;
          end
        end else if (done_q < tot_q) cmd_o.pack = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_LOAD; len_q <= LenW'(64); bits_q <= 4'd4; cnt_q <= '0;
      n_q <= '0; pair_q <= '0; k_q <= '0; bkp_q <= '0; byte_q <= '0;
      tot_q <= '0; done_q <= '0; fill_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CfgLen) len_q <= cfg_data_i;
        else bits_q <= cfg_data_i[3:0];
      end
      case (st_q)
        S_LOAD: if (in_valid_i) begin
          if (cnt_q + LenW'(1) >= len_c) begin
            cnt_q <= '0; n_q <= len_c; pair_q <= '0; k_q <= '0; st_q <= S_RD;
          end else cnt_q <= cnt_q + LenW'(1);
        end
        S_RD:   st_q <= S_GO;
        S_GO:   st_q <= S_WAIT;
        S_WAIT: if (sts_i.cordic_done) begin
          k_q <= k_q + LenW'(1);
          if (pair_q + LenW'(1) < (n_q >> 1)) begin
            pair_q <= pair_q + LenW'(1); st_q <= S_RD;
          end else if (n_q[0]) begin
            pair_q <= pair_q + LenW'(1); st_q <= S_ODD;
          end else begin
            n_q <= n_q >> 1; pair_q <= '0;
            st_q <= (n_q >> 1) > LenW'(1) ? S_RD : S_ROOT;
          end
        end
        S_ODD:  st_q <= S_ODDW;
        S_ODDW: begin
          n_q <= (n_q + LenW'(1)) >> 1; pair_q <= '0;
          st_q <= ((n_q + LenW'(1)) >> 1) > LenW'(1) ? S_RD : S_ROOT;
        end
        S_ROOT:  st_q <= S_ROOTW;
        S_ROOTW: begin
          bkp_q <= '0; byte_q <= '0; done_q <= '0; fill_q <= '0;
          tot_q <= 10'(len_c - LenW'(1)) * 10'(bits_c);
          st_q <= S_BKRD;
        end
        S_BKRD: st_q <= S_PACK;
        S_PACK: begin
          if (cmd_o.emit) begin
            byte_q <= byte_q + 6'd1;
            fill_q <= fill_q > 5'd8 ? fill_q - 5'd8 : 5'd0;
            if (cmd_o.emit_last) st_q <= S_LOAD;
          end else if (cmd_o.pack) begin
            done_q <= done_q + 10'(bits_c);
            fill_q <= fill_q + 5'(bits_c);
            bkp_q  <= bkp_q + LenW'(1);
            st_q   <= S_BKRD;
          end
        end
        default: st_q <= S_LOAD;
      endcase
    end
  end
endmodule

// ===== design/polar_angle_vector_encoder.sv =====
// polar angle vector encoder: loads a vector, then reduces it pair by pair
// with one shared cordic unit and emits packed angle code bytes
// after the last element each pair is read, rotated by the cordic unit and written back,
// then each bucket is read and packed and each full byte emitted; input stalls until
// the last byte is emitted, and while loading one element per cycle is taken
// reset: asynchronous active low, clears control, stores hold undefined data
module polar_angle_vector_encoder #(
  parameter int unsigned MAX_DIM      = pave_pkg::MaxDim,
  parameter int unsigned CORDIC_STEPS = pave_pkg::CordicSteps
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [0:0]                    cfg_index_i,
  input  logic [pave_pkg::LenW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [pave_pkg::ElemW-1:0]    element_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    code_byte_o,
  output logic [5:0]                    byte_index_o,
  output logic [pave_pkg::RadW-1:0]     radius_o,
  output logic                          last_o
);
  import pave_pkg::*;

  localparam int unsigned AW = $clog2(MAX_DIM);

  cmd_t          cmd;
  sts_t          sts;
  logic [AW-1:0] wr_idx, rd_idx, bk_idx;
  logic          bk_full;
  logic [3:0]    bits;
  logic [5:0]    byte_idx;

  pave_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .sts_i(sts), .cmd_o(cmd), .wr_idx_o(wr_idx),
    .rd_idx_o(rd_idx), .bk_idx_o(bk_idx), .bk_full_o(bk_full), .bits_o(bits),
    .byte_idx_o(byte_idx)
  );

  pave_dp #(.MAX_DIM(MAX_DIM), .CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .wr_idx_i(wr_idx),
    .rd_idx_i(rd_idx), .bk_idx_i(bk_idx), .bk_full_i(bk_full), .bits_i(bits),
    .element_i, .byte_idx_i(byte_idx), .out_stall_i, .out_valid_o,
    .code_byte_o, .byte_index_o, .radius_o, .last_o
  );
endmodule

// ===== tb/sv/pave_checker.sv =====
`timescale 1ns / 1ps
// checker for the polar angle vector encoder: watches config, element and code byte beats
// predicts the code bytes and radius of each vector; depends on pave_pkg
module pave_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [0:0]                 cfg_index_i,
  input  logic [pave_pkg::LenW-1:0]  cfg_data_i,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic [pave_pkg::ElemW-1:0] element_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic [7:0]                 code_byte_i,
  input  logic [5:0]                 byte_index_i,
  input  logic [pave_pkg::RadW-1:0]  radius_i,
  input  logic                       last_i,
  output int                         pending_o,
  output int                         fail_o
);
  import pave_pkg::*;

  localparam longint HalfPiU = 64'sd1073741824;
  localparam longint PiU     = 64'sd2147483648;

  typedef struct {
    logic [7:0]      code;
    logic [5:0]      idx;
    logic [RadW-1:0] rad;
    logic            last;
  } code_beat_t;

  localparam longint AtanUnits [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0};

  code_beat_t      code_q[$];
  int              level_mem [MaxDim];
  logic [7:0]      bucket_mem [MaxDim];
  int unsigned     elem_cnt;
  logic [LenW-1:0] len_reg;
  logic [BitsW-1:0] bits_reg;
  int              fails;

  assign pending_o = code_q.size();
  assign fail_o    = fails;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    fails++;
  endtask

  function automatic void polar_pair(input longint xi, input longint yi,
                                     output longint mag, output longint ang);
    longint x, y, z, t, dx, dy;
    logic [63:0] prod;
    x = xi;
    y = yi;
    z = 0;
    if (y == 0) begin
      mag = (x < 0) ? -x : x;
      ang = (x < 0) ? PiU : 0;
      return;
    end
    if (x == 0) begin
      mag = (y < 0) ? -y : y;
      ang = (y > 0) ? HalfPiU : -HalfPiU;
      return;
    end
    // pre-rotate into the right half plane
    if (x < 0) begin
      t = x;
      if (y > 0) begin
        x = y; y = -t; z = HalfPiU;
      end else begin
        x = -y; y = t; z = -HalfPiU;
      end
    end
    x = x * 16;
    y = y * 16;
    for (int i = 0; i < CordicSteps && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += AtanUnits[i];
      end else begin
        x -= dx; y += dy; z -= AtanUnits[i];
      end
    end
    if (x < 0) x = 0;
    // wraps at 64 bits on huge radii, same as the hardware product
    prod = 64'(x) * 64'd652032874 + (64'd1 << 33);
    mag = longint'(prod >> 34);
    ang = z;
  endfunction

  function automatic logic [7:0] bucket_of(input longint ang, input bit full, input int nb);
    logic [31:0] u;
    longint n;
    if (full) begin
      u = ang[31:0];
      return 8'(u >> (32 - nb));
    end
    n = ang + HalfPiU;
    if (n < 0) n = 0;
    if (n > PiU - 1) n = PiU - 1;
    return 8'(n >> (31 - nb));
  endfunction

  function automatic void encode_vector(input int len, input int nb);
    int n, k, pairs, nbytes, pos;
    longint mag, ang, root;
    logic [7:0] packed_bytes [MaxDim];
    code_beat_t b;
    k = 0;
    n = len;
    while (n > 1) begin
      pairs = n / 2;
      for (int i = 0; i < pairs; i++) begin
        polar_pair(level_mem[2*i], level_mem[2*i+1], mag, ang);
        if (mag > 64'sh7FFFFFFF) mag = 64'sh7FFFFFFF;
        level_mem[i] = int'(mag);
        bucket_mem[k] = bucket_of(ang, (k + 2 == len), nb);
        k++;
      end
      if (n % 2) level_mem[pairs] = level_mem[n-1];
      n = (n + 1) / 2;
    end
    root = level_mem[0];
    if (root < 0) root = -root;
    foreach (packed_bytes[i]) packed_bytes[i] = '0;
    for (int j = 0; j + 1 < len; j++)
      for (int i = 0; i < nb; i++) begin
        pos = j * nb + i;
        if (bucket_mem[j][i]) packed_bytes[(pos >> 3) % MaxDim][pos & 7] = 1'b1;
      end
    nbytes = ((len - 1) * nb + 7) / 8;
    for (int i = 0; i < nbytes; i++) begin
      b.code = packed_bytes[i];
      b.idx  = 6'(i);
      b.rad  = RadW'(root);
      b.last = (i + 1 == nbytes);
      code_q.insert(code_q.size(), b);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    int len, nb;
    code_beat_t want;
    if (!rst_ni) begin
      elem_cnt = 0;
      len_reg  = LenW'(64);
      bits_reg = BitsW'(4);
      code_q.delete();
      fails    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CfgLen) len_reg = cfg_data_i;
        else bits_reg = cfg_data_i[BitsW-1:0];
      end
      if (in_valid_i && !in_stall_i) begin
        len = (len_reg < 2) ? 2 : (len_reg > MaxDim) ? MaxDim : len_reg;
        nb  = (bits_reg < 1) ? 1 : (bits_reg > 8) ? 8 : bits_reg;
        if (elem_cnt < MaxDim) level_mem[elem_cnt] = int'($signed(element_i));
        elem_cnt = (elem_cnt + 1) & 7'h7F;
        if (elem_cnt >= len) begin
          elem_cnt = 0;
          encode_vector(len, nb);
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (code_q.size() == 0) begin
          report_mismatch("unexpected code beat, byte_index", byte_index_i, -1);
        end else begin
          want = code_q.pop_front();
          if (code_byte_i !== want.code) report_mismatch("code_byte", code_byte_i, want.code);
          if (byte_index_i !== want.idx) report_mismatch("byte_index", byte_index_i, want.idx);
          if (radius_i !== want.rad) report_mismatch("radius", radius_i, want.rad);
          if (last_i !== want.last) report_mismatch("last", last_i, want.last);
        end
      end
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// top of the polar angle vector encoder testbench: clock, reset, stimulus, verdict
// depends on pave_pkg, polar_angle_vector_encoder and pave_checker
module tb_top;
  import pave_pkg::*;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [0:0]        cfg_index_i = CfgLen;
  logic [LenW-1:0]   cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [ElemW-1:0]  element_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [7:0]        code_byte_o;
  logic [5:0]        byte_index_o;
  logic [RadW-1:0]   radius_o;
  logic              last_o;
  int                pending, fail_count;
  bit                hold_req = 1'b0;
  int                stall_mode = 0;

  localparam logic [ElemW-1:0] EMax = 24'h7FFFFF;
  localparam logic [ElemW-1:0] EMin = 24'h800000;

  always #10 clk_i = ~clk_i;

  polar_angle_vector_encoder dut (.*);

  pave_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .element_i,
    .out_valid_i(out_valid_o), .out_stall_i, .code_byte_i(code_byte_o),
    .byte_index_i(byte_index_o), .radius_i(radius_o), .last_i(last_o),
    .pending_o(pending), .fail_o(fail_count)
  );

  // called at a falling edge, returns at a falling edge
  task automatic write_reg(input logic [0:0] idx, input int value);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = LenW'(value);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic send_element(input logic [ElemW-1:0] e);
    in_valid_i = 1'b1;
    element_i  = e;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain;
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  function automatic logic [ElemW-1:0] rand_element();
    case ($urandom_range(0, 6))
      0: return ElemW'($urandom_range(0, 128)) - ElemW'(64);
      1: return '0;
      2: return $urandom_range(0, 1) ? EMax : EMin;
      3: return ElemW'($signed(12'($urandom())));
      default: return ElemW'($urandom());
    endcase
  endfunction

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int cyc;
    cyc = 0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc % 64 == 0) stall_mode = $urandom_range(0, 2);
      if (hold_req) begin
        out_stall_i = 1'b1;
        repeat (3000) @(negedge clk_i);
        out_stall_i = 1'b0;
        hold_req = 1'b0;
      end else begin
        case (stall_mode)
          0: out_stall_i = 1'b0;
          1: out_stall_i = ($urandom_range(0, 2) == 0);
          default: out_stall_i = (cyc % 8) < 5;
        endcase
      end
    end
  end

  initial begin
    #30ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int lens [6] = '{127, 5, 2, 9, 33, 1};
    int bits [6] = '{8, 3, 1, 7, 6, 15};
    int sent, burst, gap;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // pairs at length two (zero clamps up), last angle covers the full circle
    write_reg(CfgLen, 0);
    write_reg(CfgBits, 8);
    send_element('0);   send_element('0);
    send_element(EMax); send_element('0);
    send_element(EMin); send_element('0);
    send_element('0);   send_element(EMax);
    send_element('0);   send_element(EMin);
    send_element(-24'sd5000); send_element(24'sd3000);
    send_element(-24'sd5000); send_element(-24'sd3000);
    send_element(EMax); send_element(EMax);
    send_element(EMin); send_element(EMin);
    send_element(EMax); send_element(EMin);
    send_element(24'd1); send_element(-24'sd1);
    drain();
    // odd leftover and a clamped half-circle angle, one bit per bucket
    write_reg(CfgLen, 3);
    write_reg(CfgBits, 0);
    send_element(EMin); send_element(EMax); send_element(-24'sd7);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_reg(CfgLen, lens[p]);
      write_reg(CfgBits, bits[p]);
      if (p == 0) hold_req = 1'b1;
      sent = 0;
      burst = 0;
      // whole vectors, at least 5 elements per phase
      while (sent < 5 || (sent % ((lens[p] < 2) ? 2 : (lens[p] > 64) ? 64 : lens[p])) != 0)
      begin
        if (burst == 0) begin
          burst = $urandom_range(1, 12);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          if (gap != 0) begin
            in_valid_i = 1'b0;
            repeat (gap) @(negedge clk_i);
          end
        end
        send_element(rand_element());
        burst--;
        sent++;
      end
      drain();
    end

    repeat (200) @(negedge clk_i);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== polar_angle_vector_encoder.f =====
design/pave_pkg.sv
design/pave_dp.sv
design/pave_ctrl.sv
design/polar_angle_vector_encoder.sv
tb/sv/pave_checker.sv
tb/sv/tb_top.sv
